// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// Needs nothing else; take in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while reset is released
`define SRDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released
`define SRDC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/srdc_pkg.sv =====
// Package for the stepper ramp and direction controller: state and opcode
// codes, register indexes, reset values and the structs shared by the modules.
`default_nettype none

package srdc_pkg;

    localparam int FREQ_BITS_DEF = 24;   // internal frequency register width
    localparam int FREQ_PORT_W   = 24;   // frequency width at the ports
    localparam int VALUE_W       = 24;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [7:0]  INTERVAL_RST = 8'd10;
    localparam logic [15:0] STEP_RST     = 16'd100;
    localparam logic [15:0] HOLD_RST     = 16'd1000;
    localparam int          FREQ_RST     = 10000;
    localparam logic [6:0]  DUTY_RST     = 7'd50;
    localparam logic [7:0]  DUTY_MAX     = 8'd100;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_START  = 3'd1,
        ST_RUN    = 3'd2,
        ST_STOP   = 3'd3,
        ST_RAMP   = 3'd4,
        ST_DIRCHG = 3'd5,
        ST_AUTO   = 3'd6
    } t_seq_state;

    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_START    = 4'd1,
        OP_STOP     = 4'd2,
        OP_FORWARD  = 4'd3,
        OP_REVERSE  = 4'd4,
        OP_SET_FREQ = 4'd5,
        OP_SET_DUTY = 4'd6,
        OP_AUTO_ON  = 4'd7,
        OP_AUTO_OFF = 4'd8,
        OP_MARK     = 4'd9
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_INTERVAL = 2'd0,
        CFG_RAMP_STEP     = 2'd1,
        CFG_RELAY_HOLD    = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [7:0]  ramp_interval;
        logic [15:0] ramp_step;
        logic [15:0] relay_hold;
    } t_cfg;

    typedef struct packed {
        logic [FREQ_PORT_W-1:0] current_freq;
        logic                   direction;
        logic                   drive_enable;
        logic [6:0]             duty_percent;
        logic                   relay_on;
        t_seq_state             motor_state;
        logic                   event_taken;
        logic                   duty_error;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/stepper_ramp_direction_controller_unit.sv =====
// Stepper ramp and direction controller: input register, sequencer and result
// register with valid/ready handshake. Depends on srdc_pkg and srdc_seq.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries one command event
//   (i_opcode, i_value) and an optional millisecond tick (i_ms_tick).
//   Output channel (o_out_valid/i_out_ready) returns one result transaction
//   per input transaction: frequency, direction, enable, duty, relay, state
//   and the command status flags, all after the item has been applied.
//   Configuration channel (i_cfg_valid/o_cfg_ready) writes ramp interval,
//   ramp step and relay hold by index; write only while the block is idle.
//   Path: an accepted item is held in the input register, then moves to
//   the result register. Throughput: one item per cycle while results are
//   taken; the sequencer updates its state in the same cycle as the item
//   moves from the input register to the result register.
//   Reset: sequencer in the stop state, frequency 0, targets 10000 Hz,
//   duty 50 %, relay off, registers at their reset values; no clearing pass.
//   Stall: while the result register is full and not taken, the input
//   register holds one more item; o_in_ready drops only when both are full.
`default_nettype none

module stepper_ramp_direction_controller_unit #(
    parameter int FREQ_BITS = srdc_pkg::FREQ_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [3:0]                          i_opcode,
    input  wire logic [srdc_pkg::VALUE_W-1:0]        i_value,
    input  wire logic                                i_ms_tick,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [srdc_pkg::FREQ_PORT_W-1:0]         o_current_freq,
    output logic                                     o_direction,
    output logic                                     o_drive_enable,
    output logic [6:0]                               o_duty_percent,
    output logic                                     o_relay_on,
    output logic [2:0]                               o_motor_state,
    output logic                                     o_event_taken,
    output logic                                     o_duty_error,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [srdc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [srdc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import srdc_pkg::*;

    t_cfg                r_cfg;
    logic                r_s1_valid;
    logic [3:0]          r_s1_opcode;
    logic [VALUE_W-1:0]  r_s1_value;
    logic                r_s1_tick;
    logic                r_out_valid;
    t_result             r_out;
    t_result             seq_result;
    logic                advance;
    logic                in_fire;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_interval <= INTERVAL_RST;
            r_cfg.ramp_step     <= STEP_RST;
            r_cfg.relay_hold    <= HOLD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RAMP_INTERVAL: r_cfg.ramp_interval <= i_cfg_data[7:0];
                CFG_RAMP_STEP:     r_cfg.ramp_step     <= i_cfg_data;
                CFG_RELAY_HOLD:    r_cfg.relay_hold    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // move the held item into the result register when that slot frees up
    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_opcode <= i_opcode;
            r_s1_value  <= i_value;
            r_s1_tick   <= i_ms_tick;
        end
    end

    srdc_seq #(
        .FREQ_BITS(FREQ_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_opcode (r_s1_opcode),
        .i_value  (r_s1_value),
        .i_ms_tick(r_s1_tick),
        .i_cfg    (r_cfg),
        .o_result (seq_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= seq_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_current_freq = r_out.current_freq;
    assign o_direction    = r_out.direction;
    assign o_drive_enable = r_out.drive_enable;
    assign o_duty_percent = r_out.duty_percent;
    assign o_relay_on     = r_out.relay_on;
    assign o_motor_state  = r_out.motor_state;
    assign o_event_taken  = r_out.event_taken;
    assign o_duty_error   = r_out.duty_error;

endmodule

`default_nettype wire

// ===== rtl/core/srdc_ramp.sv =====
// Linear ramp step: moves the frequency one step toward its target once the
// ramp interval has elapsed, snapping to the target once near it. Uses srdc_pkg.
`default_nettype none

module srdc_ramp #(
    parameter int FREQ_BITS = srdc_pkg::FREQ_BITS_DEF
) (
    input  wire logic                 i_en,
    input  wire logic [FREQ_BITS-1:0] i_freq_now,
    input  wire logic [FREQ_BITS-1:0] i_freq_target,
    input  wire logic [7:0]           i_elapsed,
    input  wire logic [7:0]           i_interval,
    input  wire logic [15:0]          i_step,
    output logic      [FREQ_BITS-1:0] o_freq_next,
    output logic      [7:0]           o_elapsed_next
);
    import srdc_pkg::*;

    localparam int GW = FREQ_BITS + 1;

    logic          fire;
    logic [GW-1:0] gap_up;
    logic [GW-1:0] gap_dn;
    logic [GW-1:0] step_w;

    assign fire   = i_en && (i_elapsed >= i_interval);
    assign step_w = GW'(i_step);
    assign gap_up = {1'b0, i_freq_target} - {1'b0, i_freq_now};
    assign gap_dn = {1'b0, i_freq_now} - {1'b0, i_freq_target};

    always_comb begin
        o_freq_next    = i_freq_now;
        o_elapsed_next = i_elapsed;
        if (fire) begin
            o_elapsed_next = '0;
            if (i_freq_target > i_freq_now) begin
                // snap when less than two steps remain
                if (gap_up < (step_w << 1)) begin
                    o_freq_next = i_freq_target;
                end else begin
                    o_freq_next = i_freq_now + FREQ_BITS'(i_step);
                end
            end else if (i_freq_target < i_freq_now) begin
                if (gap_dn > step_w) begin
                    o_freq_next = i_freq_now - FREQ_BITS'(i_step);
                end else begin
                    o_freq_next = i_freq_target;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/srdc_seq.sv =====
// Motor sequencer: command gate, seven-state sequence, relay timer and the
// state registers. Depends on srdc_pkg and srdc_ramp.
`default_nettype none

module srdc_seq #(
    parameter int FREQ_BITS = srdc_pkg::FREQ_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_advance,
    input  wire logic [3:0]                      i_opcode,
    input  wire logic [srdc_pkg::VALUE_W-1:0]    i_value,
    input  wire logic                            i_ms_tick,
    input  wire srdc_pkg::t_cfg                  i_cfg,
    output srdc_pkg::t_result                    o_result
);
    import srdc_pkg::*;

    t_seq_state           r_state,       n_state;
    logic [FREQ_BITS-1:0] r_freq_now,    n_freq_now;
    logic [FREQ_BITS-1:0] r_freq_target, n_freq_target;
    logic [FREQ_BITS-1:0] r_freq_req,    n_freq_req;
    logic                 r_dir_now,     n_dir_now;
    logic                 r_dir_target,  n_dir_target;
    logic                 r_dir_next,    n_dir_next;
    logic [6:0]           r_duty,        n_duty;
    logic                 r_enable,      n_enable;
    logic                 r_auto,        n_auto;
    logic [7:0]           r_ramp_el,     n_ramp_el;
    logic                 r_relay,       n_relay;
    logic [15:0]          r_relay_el,    n_relay_el;

    // values after the tick and the command, before the sequence step
    t_seq_state           c_state;
    logic [FREQ_BITS-1:0] c_target;
    logic [FREQ_BITS-1:0] c_req;
    logic                 c_dir_target;
    logic                 c_dir_next;
    logic [6:0]           c_duty;
    logic                 c_auto;
    logic                 c_relay;
    logic [15:0]          c_relay_el;
    logic [7:0]           c_ramp_el;
    logic                 taken;
    logic                 duty_err;
    logic                 bare_ok;

    logic                 ramp_en;
    logic [FREQ_BITS-1:0] ramp_target;
    logic [FREQ_BITS-1:0] ramp_freq;
    logic [7:0]           ramp_el;

    assign bare_ok = (i_value == '0);

    always_comb begin
        c_ramp_el    = r_ramp_el;
        c_relay_el   = r_relay_el;
        c_state      = r_state;
        c_target     = r_freq_target;
        c_req        = r_freq_req;
        c_dir_target = r_dir_target;
        c_dir_next   = r_dir_next;
        c_duty       = r_duty;
        c_auto       = r_auto;
        c_relay      = r_relay;
        taken        = 1'b0;
        duty_err     = 1'b0;

        // saturating millisecond counters
        if (i_ms_tick) begin
            if (r_ramp_el != 8'hFF) begin
                c_ramp_el = r_ramp_el + 8'd1;
            end
            if (r_relay && (r_relay_el != 16'hFFFF)) begin
                c_relay_el = r_relay_el + 16'd1;
            end
        end

        if ((r_state == ST_IDLE) || (r_state == ST_AUTO)) begin
            case (i_opcode)
                OP_START: begin
                    if (bare_ok) begin
                        taken = 1'b1;
                        if ((r_state == ST_AUTO) && (r_dir_now != r_dir_next)) begin
                            c_state = ST_RAMP;
                        end else begin
                            c_state = ST_START;
                        end
                    end
                end
                OP_STOP: begin
                    if (bare_ok) begin
                        taken = 1'b1;
                        if (r_state != ST_AUTO) begin
                            c_state = ST_STOP;
                        end
                    end
                end
                OP_FORWARD, OP_REVERSE: begin
                    if (bare_ok) begin
                        taken = 1'b1;
                        if (r_auto) begin
                            c_dir_next = (i_opcode == OP_FORWARD);
                            c_state    = ST_AUTO;
                        end else begin
                            c_dir_target = (i_opcode == OP_FORWARD);
                            c_state      = ST_DIRCHG;
                        end
                    end
                end
                OP_SET_FREQ: begin
                    taken    = 1'b1;
                    c_req    = FREQ_BITS'(i_value);
                    c_target = FREQ_BITS'(i_value);
                end
                OP_SET_DUTY: begin
                    taken = 1'b1;
                    if (i_value[7:0] > DUTY_MAX) begin
                        duty_err = 1'b1;
                    end else begin
                        c_duty = i_value[6:0];
                    end
                end
                OP_AUTO_ON: begin
                    if (bare_ok) begin
                        taken  = 1'b1;
                        c_auto = 1'b1;
                    end
                end
                OP_AUTO_OFF: begin
                    if (bare_ok) begin
                        taken  = 1'b1;
                        c_auto = 1'b0;
                    end
                end
                OP_MARK: begin
                    if (bare_ok) begin
                        taken      = 1'b1;
                        c_relay    = 1'b1;
                        c_relay_el = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // stop and direction change ramp toward zero
    assign ramp_en     = (c_state == ST_RUN) || (c_state == ST_STOP) || (c_state == ST_DIRCHG);
    assign ramp_target = ((c_state == ST_STOP) || (c_state == ST_DIRCHG)) ? '0 : c_target;

    srdc_ramp #(
        .FREQ_BITS(FREQ_BITS)
    ) u_ramp (
        .i_en          (ramp_en),
        .i_freq_now    (r_freq_now),
        .i_freq_target (ramp_target),
        .i_elapsed     (c_ramp_el),
        .i_interval    (i_cfg.ramp_interval),
        .i_step        (i_cfg.ramp_step),
        .o_freq_next   (ramp_freq),
        .o_elapsed_next(ramp_el)
    );

    always_comb begin
        n_state       = c_state;
        n_freq_now    = ramp_freq;
        n_freq_target = c_target;
        n_freq_req    = c_req;
        n_dir_now     = r_dir_now;
        n_dir_target  = c_dir_target;
        n_dir_next    = c_dir_next;
        n_duty        = c_duty;
        n_enable      = r_enable;
        n_auto        = c_auto;
        n_ramp_el     = ramp_el;
        n_relay       = c_relay;
        n_relay_el    = c_relay_el;

        unique case (c_state)
            ST_START: begin
                n_freq_target = c_req;
                n_enable      = 1'b1;
                n_state       = ST_RUN;
            end
            ST_RUN: begin
                if (ramp_freq == c_target) begin
                    n_state = ST_IDLE;
                end
            end
            ST_STOP: begin
                n_freq_target = '0;
                if (ramp_freq == '0) begin
                    n_enable = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            ST_DIRCHG: begin
                n_freq_target = '0;
                if (ramp_freq == '0) begin
                    n_dir_now = c_dir_target;
                    if (c_auto) begin
                        n_state = ST_START;
                    end else begin
                        n_enable = 1'b0;
                        n_state  = ST_IDLE;
                    end
                end
            end
            ST_RAMP: begin
                n_dir_target = c_dir_next;
                n_state      = ST_DIRCHG;
            end
            default: begin
            end
        endcase

        // release the relay once the hold time is exceeded
        if (c_relay && (c_relay_el > i_cfg.relay_hold)) begin
            n_relay = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_STOP;
            r_freq_now    <= '0;
            r_freq_target <= FREQ_BITS'(FREQ_RST);
            r_freq_req    <= FREQ_BITS'(FREQ_RST);
            r_dir_now     <= 1'b0;
            r_dir_target  <= 1'b0;
            r_dir_next    <= 1'b0;
            r_duty        <= DUTY_RST;
            r_enable      <= 1'b0;
            r_auto        <= 1'b0;
            r_ramp_el     <= '0;
            r_relay       <= 1'b0;
            r_relay_el    <= '0;
        end else if (i_advance) begin
            r_state       <= n_state;
            r_freq_now    <= n_freq_now;
            r_freq_target <= n_freq_target;
            r_freq_req    <= n_freq_req;
            r_dir_now     <= n_dir_now;
            r_dir_target  <= n_dir_target;
            r_dir_next    <= n_dir_next;
            r_duty        <= n_duty;
            r_enable      <= n_enable;
            r_auto        <= n_auto;
            r_ramp_el     <= n_ramp_el;
            r_relay       <= n_relay;
            r_relay_el    <= n_relay_el;
        end
    end

    always_comb begin
        o_result.current_freq = FREQ_PORT_W'(n_freq_now);
        o_result.direction    = n_dir_now;
        o_result.drive_enable = n_enable;
        o_result.duty_percent = n_duty;
        o_result.relay_on     = n_relay;
        o_result.motor_state  = n_state;
        o_result.event_taken  = taken;
        o_result.duty_error   = duty_err;
    end

endmodule

`default_nettype wire

// ===== rtl/core/srdc_checker.sv =====
// Port-level checker for the stepper ramp and direction controller, bound to
// the top level. Depends on assert_macros.svh and srdc_pkg.
`default_nettype none
`include "assert_macros.svh"

module srdc_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_out_ready,
    input wire logic                                o_out_valid,
    input wire logic [srdc_pkg::FREQ_PORT_W-1:0]    o_current_freq,
    input wire logic [6:0]                          o_duty_percent,
    input wire logic                                o_event_taken,
    input wire logic                                o_duty_error
);
    import srdc_pkg::*;

    // handshake check: a stalled result transaction stays valid and holds its frequency
    `SRDC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `SRDC_ASSERT_NXT(a_freq_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_current_freq), "result changed while stalled")
    // a rejected duty value is still a taken command
    `SRDC_ASSERT_IMP(a_derr_taken, i_clk, i_rst_n, o_out_valid && o_duty_error, o_event_taken, "duty error without taken command")
    // duty never leaves the legal range
    `SRDC_ASSERT_IMP(a_duty_range, i_clk, i_rst_n, o_out_valid, {1'b0, o_duty_percent} <= DUTY_MAX, "duty above limit")

endmodule

bind stepper_ramp_direction_controller_unit srdc_checker u_srdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_ready   (i_out_ready),
    .o_out_valid   (o_out_valid),
    .o_current_freq(o_current_freq),
    .o_duty_percent(o_duty_percent),
    .o_event_taken (o_event_taken),
    .o_duty_error  (o_duty_error)
);

`default_nettype wire

// ===== test/tb_stepper_ramp_direction_controller_unit.sv =====
// Self-checking bench for the stepper ramp and direction controller unit.
// Feeds directed and random command transactions and checks each status result.
// Needs srdc_pkg and stepper_ramp_direction_controller_unit.
module tb_stepper_ramp_direction_controller_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import srdc_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam logic [3:0] OP_RESERVED_LO = 4'hA;
    localparam logic [3:0] OP_RESERVED_HI = 4'hF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic [3:0]         op;
        logic [VALUE_W-1:0] val;
        logic               tick;
        bit                 typed;
        t_result            res;
    } t_row;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    logic [3:0]             i_opcode    = '0;
    logic [VALUE_W-1:0]     i_value     = '0;
    logic                   i_ms_tick   = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [FREQ_PORT_W-1:0] o_current_freq;
    logic                   o_direction;
    logic                   o_drive_enable;
    logic [6:0]             o_duty_percent;
    logic                   o_relay_on;
    logic [2:0]             o_motor_state;
    logic                   o_event_taken;
    logic                   o_duty_error;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // sequencer copy kept in step with every accepted transaction
    logic [7:0]               m_interval;
    logic [15:0]              m_step;
    logic [15:0]              m_hold;
    t_seq_state               m_state;
    logic [FREQ_BITS_DEF-1:0] m_freq;
    logic [FREQ_BITS_DEF-1:0] m_target;
    logic [FREQ_BITS_DEF-1:0] m_requested;
    logic                     m_dir;
    logic                     m_dir_target;
    logic                     m_dir_next;
    logic                     m_enable;
    logic                     m_auto;
    logic                     m_relay;
    logic [6:0]               m_duty;
    logic [7:0]               m_ramp_ms;
    logic [15:0]              m_relay_ms;

    t_result     expected_status[$];
    int unsigned mismatches    = 0;
    int unsigned send_gap_pct  = 26;
    int unsigned take_gap_pct  = 52;
    int unsigned hold_off_left = 0;

    stepper_ramp_direction_controller_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_value        (i_value),
        .i_ms_tick      (i_ms_tick),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_current_freq (o_current_freq),
        .o_direction    (o_direction),
        .o_drive_enable (o_drive_enable),
        .o_duty_percent (o_duty_percent),
        .o_relay_on     (o_relay_on),
        .o_motor_state  (o_motor_state),
        .o_event_taken  (o_event_taken),
        .o_duty_error   (o_duty_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void reset_sequencer();
        m_interval   = INTERVAL_RST;
        m_step       = STEP_RST;
        m_hold       = HOLD_RST;
        m_state      = ST_STOP;
        m_freq       = '0;
        m_target     = FREQ_BITS_DEF'(FREQ_RST);
        m_requested  = FREQ_BITS_DEF'(FREQ_RST);
        m_dir        = 1'b0;
        m_dir_target = 1'b0;
        m_dir_next   = 1'b0;
        m_duty       = DUTY_RST;
        m_enable     = 1'b0;
        m_auto       = 1'b0;
        m_ramp_ms    = '0;
        m_relay      = 1'b0;
        m_relay_ms   = '0;
    endfunction

    // One ramp step once the interval has run out; never pass the target.
    function automatic void ramp_toward_target();
        logic [FREQ_BITS_DEF-1:0] gap;
        if (m_ramp_ms < m_interval)
            return;
        m_ramp_ms = '0;
        if (m_target > m_freq) begin
            gap = m_target - m_freq;
            if (gap < {m_step, 1'b0})
                m_freq = m_target;
            else
                m_freq = m_freq + FREQ_BITS_DEF'(m_step);
        end else if (m_target < m_freq) begin
            gap = m_freq - m_target;
            if (gap > m_step)
                m_freq = m_freq - FREQ_BITS_DEF'(m_step);
            else
                m_freq = m_target;
        end
    endfunction

    function automatic t_result advance_sequencer(logic [3:0] op, logic [VALUE_W-1:0] val,
                                                  logic tick);
        t_result    res;
        logic       taken;
        logic       derr;
        logic [7:0] duty_req;
        taken = 1'b0;
        derr  = 1'b0;
        if (tick) begin
            if (m_ramp_ms != 8'hFF)
                m_ramp_ms++;
            if (m_relay && m_relay_ms != 16'hFFFF)
                m_relay_ms++;
        end

        if ((m_state == ST_IDLE || m_state == ST_AUTO) && op >= OP_START && op <= OP_MARK &&
            (op == OP_SET_FREQ || op == OP_SET_DUTY || val == '0)) begin
            taken = 1'b1;
            case (op)
                OP_START: begin
                    if (m_state == ST_AUTO && m_dir != m_dir_next)
                        m_state = ST_RAMP;
                    else
                        m_state = ST_START;
                end
                OP_STOP: begin
                    if (m_state != ST_AUTO)
                        m_state = ST_STOP;
                end
                OP_FORWARD, OP_REVERSE: begin
                    if (m_auto) begin
                        m_dir_next = (op == OP_FORWARD);
                        m_state    = ST_AUTO;
                    end else begin
                        m_dir_target = (op == OP_FORWARD);
                        m_state      = ST_DIRCHG;
                    end
                end
                OP_SET_FREQ: begin
                    m_requested = val[FREQ_BITS_DEF-1:0];
                    m_target    = val[FREQ_BITS_DEF-1:0];
                end
                OP_SET_DUTY: begin
                    duty_req = val[7:0];
                    if (duty_req > DUTY_MAX)
                        derr = 1'b1;
                    else
                        m_duty = duty_req[6:0];
                end
                OP_AUTO_ON:  m_auto = 1'b1;
                OP_AUTO_OFF: m_auto = 1'b0;
                default: begin
                    m_relay    = 1'b1;
                    m_relay_ms = '0;
                end
            endcase
        end

        case (m_state)
            ST_START: begin
                m_target = m_requested;
                m_enable = 1'b1;
                m_state  = ST_RUN;
            end
            ST_RUN: begin
                ramp_toward_target();
                if (m_freq == m_target)
                    m_state = ST_IDLE;
            end
            ST_STOP: begin
                m_target = '0;
                ramp_toward_target();
                if (m_freq == '0) begin
                    m_enable = 1'b0;
                    m_state  = ST_IDLE;
                end
            end
            ST_DIRCHG: begin
                m_target = '0;
                ramp_toward_target();
                if (m_freq == '0) begin
                    m_dir = m_dir_target;
                    if (m_auto) begin
                        m_state = ST_START;
                    end else begin
                        m_enable = 1'b0;
                        m_state  = ST_IDLE;
                    end
                end
            end
            ST_RAMP: begin
                m_dir_target = m_dir_next;
                m_state      = ST_DIRCHG;
            end
            default: ;
        endcase

        if (m_relay && m_relay_ms > m_hold)
            m_relay = 1'b0;

        res.current_freq = m_freq;
        res.direction    = m_dir;
        res.drive_enable = m_enable;
        res.duty_percent = m_duty;
        res.relay_on     = m_relay;
        res.motor_state  = m_state;
        res.event_taken  = taken;
        res.duty_error   = derr;
        return res;
    endfunction

    function automatic t_result idle_status(logic [6:0] duty, logic taken, logic derr);
        t_result r;
        r              = '0;
        r.duty_percent = duty;
        r.motor_state  = ST_IDLE;
        r.event_taken  = taken;
        r.duty_error   = derr;
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Valid stays up between back-to-back transactions; drop it only for a gap.
    task automatic send_item(logic [3:0] op, logic [VALUE_W-1:0] val, logic tick,
                             bit typed = 1'b0, t_result typed_res = '0);
        t_result predicted;
        if ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_gap_pct);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_value    <= val;
        i_ms_tick  <= tick;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = advance_sequencer(op, val, tick);
        expected_status.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_RAMP_INTERVAL: m_interval = data[7:0];
            CFG_RAMP_STEP:     m_step     = data;
            CFG_RELAY_HOLD:    m_hold     = data;
            default: ;
        endcase
    endtask

    task automatic set_profile(logic [15:0] interval, logic [15:0] step, logic [15:0] hold);
        cfg_write(CFG_RAMP_INTERVAL, interval);
        cfg_write(CFG_RAMP_STEP, step);
        cfg_write(CFG_RELAY_HOLD, hold);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly ticks and well-formed commands; some bare commands with a value
    // and reserved opcodes as noise.
    task automatic run_random(int unsigned count, int unsigned span, int unsigned big_pct,
                              bit squeeze);
        logic [3:0]         op;
        logic [VALUE_W-1:0] val;
        logic               tick;
        int unsigned        pick;
        for (int unsigned n = 0; n < count; n++) begin
            if (n == count / 4)
                drain();
            if (squeeze && n == count / 2)
                hold_off_left = HOLD_OFF_CYCLES;
            pick = $urandom_range(0, 99);
            val  = '0;
            tick = 1'($urandom_range(0, 1));
            if (pick < 45) begin
                op   = OP_NONE;
                tick = 1'b1;
            end else if (pick < 55) begin
                op = OP_NONE;
            end else if (pick < 88) begin
                op = 4'($urandom_range(OP_START, OP_MARK));
                if (op == OP_SET_FREQ)
                    val = VALUE_W'(($urandom_range(0, 99) < big_pct) ? $urandom
                                                                     : $urandom_range(0, span));
                else if (op == OP_SET_DUTY)
                    val = VALUE_W'($urandom_range(0, 1) ? $urandom
                                                        : $urandom_range(0, DUTY_MAX));
            end else if (pick < 95) begin
                op = 4'($urandom_range(OP_START, OP_MARK));
                if (op == OP_SET_FREQ)
                    op = OP_START;
                val = VALUE_W'($urandom_range(1, 24'hFFFFFF));
            end else begin
                op  = 4'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
                val = VALUE_W'($urandom);
            end
            send_item(op, val, tick);
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_left != 0) begin
                hold_off_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= take_gap_pct);
            end
        end
    end

    always @(posedge i_clk) begin : status_monitor
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_status.size() == 0) begin
                $display("%0t: status transaction with none outstanding", $time);
                mismatches++;
            end else begin
                want = expected_status.pop_front();
                compare_field("current_freq", 32'(want.current_freq), 32'(o_current_freq));
                compare_field("direction", 32'(want.direction), 32'(o_direction));
                compare_field("drive_enable", 32'(want.drive_enable), 32'(o_drive_enable));
                compare_field("duty_percent", 32'(want.duty_percent), 32'(o_duty_percent));
                compare_field("relay_on", 32'(want.relay_on), 32'(o_relay_on));
                compare_field("motor_state", 32'(want.motor_state), 32'(o_motor_state));
                compare_field("event_taken", 32'(want.event_taken), 32'(o_event_taken));
                compare_field("duty_error", 32'(want.duty_error), 32'(o_duty_error));
            end
        end
    end

    initial begin
        t_row rows [25];
        reset_sequencer();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows = '{
            '{OP_NONE,        24'd0,        1'b0, 1'b1, idle_status(7'd50, 1'b0, 1'b0)},
            '{OP_SET_DUTY,    24'd101,      1'b0, 1'b1, idle_status(7'd50, 1'b1, 1'b1)},
            '{OP_SET_DUTY,    24'hFFFFFF,   1'b1, 1'b1, idle_status(7'd50, 1'b1, 1'b1)},
            '{OP_SET_DUTY,    24'hABCD64,   1'b0, 1'b1, idle_status(7'd100, 1'b1, 1'b0)},
            '{OP_SET_DUTY,    24'd0,        1'b1, 1'b1, idle_status(7'd0, 1'b1, 1'b0)},
            '{OP_START,       24'd1,        1'b0, 1'b1, idle_status(7'd0, 1'b0, 1'b0)},
            '{OP_RESERVED_HI, 24'hFFFFFF,   1'b1, 1'b1, idle_status(7'd0, 1'b0, 1'b0)},
            '{OP_RESERVED_LO, 24'd0,        1'b0, 1'b1, idle_status(7'd0, 1'b0, 1'b0)},
            '{OP_NONE,        24'h800000,   1'b0, 1'b1, idle_status(7'd0, 1'b0, 1'b0)},
            '{OP_MARK,        24'd0,        1'b0, 1'b0, '0},
            '{OP_SET_FREQ,    24'hFFFFFF,   1'b0, 1'b0, '0},
            '{OP_SET_FREQ,    24'd0,        1'b1, 1'b0, '0},
            '{OP_START,       24'd0,        1'b0, 1'b0, '0},
            '{OP_STOP,        24'd0,        1'b1, 1'b0, '0},
            '{OP_FORWARD,     24'd0,        1'b0, 1'b0, '0},
            '{OP_REVERSE,     24'd0,        1'b1, 1'b0, '0},
            '{OP_AUTO_ON,     24'd0,        1'b0, 1'b0, '0},
            '{OP_FORWARD,     24'd0,        1'b0, 1'b0, '0},
            '{OP_STOP,        24'd0,        1'b0, 1'b0, '0},
            '{OP_START,       24'd0,        1'b0, 1'b0, '0},
            '{OP_NONE,        24'd0,        1'b1, 1'b0, '0},
            '{OP_NONE,        24'd0,        1'b0, 1'b0, '0},
            '{OP_AUTO_OFF,    24'd0,        1'b0, 1'b0, '0},
            '{OP_AUTO_OFF,    24'd0,        1'b0, 1'b0, '0},
            '{OP_STOP,        24'd0,        1'b0, 1'b0, '0}
        };
        foreach (rows[k])
            send_item(rows[k].op, rows[k].val, rows[k].tick, rows[k].typed, rows[k].res);

        // reset register values still in force
        run_random(300, 600, 0, 1'b1);
        drain();
        set_profile(16'd1, 16'd1, 16'd1);
        run_random(200, 6, 0, 1'b0);

        send_gap_pct = 52;
        take_gap_pct = 26;
        drain();
        set_profile(16'd0, 16'hFFFF, 16'hFFFF);
        run_random(300, 600000, 3, 1'b0);
        drain();
        set_profile(16'hFFFF, 16'd40000, 16'd300);
        run_random(350, 79999, 0, 1'b0);

        send_gap_pct = 0;
        take_gap_pct = 0;
        drain();
        set_profile(16'd0, 16'd0, 16'($urandom_range(1, 200)));
        run_random(100, 500, 0, 1'b0);
        drain();
        cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
        set_profile({8'($urandom_range(0, 255)), 8'd2}, 16'($urandom_range(200, 5000)),
                    16'($urandom_range(1, 200)));
        run_random(500, 20000, 0, 1'b1);
        drain();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
